FILE: rtl/rlmc_pkg.sv
// Shared types, codes and constants for the RGBW light mode controller.
`timescale 1ns / 1ps
`default_nettype none

package rlmc_pkg;

  // Item opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SET_WHITE  = 3'd1;
  localparam logic [2:0] OP_SET_COLOUR = 3'd2;
  localparam logic [2:0] OP_SWITCH     = 3'd3;
  localparam logic [2:0] OP_CYCLE      = 3'd4;

  // Switch kinds
  localparam logic [1:0] SW_ON     = 2'd0;
  localparam logic [1:0] SW_OFF    = 2'd1;
  localparam logic [1:0] SW_TOGGLE = 2'd2;
  localparam logic [1:0] SW_BAD    = 2'd3;

  // White modes
  localparam logic [2:0] WM_OFF     = 3'd0;
  localparam logic [2:0] WM_LOW     = 3'd1;
  localparam logic [2:0] WM_HALF    = 3'd2;
  localparam logic [2:0] WM_FULL    = 3'd3;
  localparam logic [2:0] WM_AUTO    = 3'd4;
  localparam logic [2:0] WM_SOS     = 3'd5;
  localparam logic [2:0] WM_TWINKLE = 3'd6;

  // Colour modes
  localparam logic [2:0] CM_OFF  = 3'd0;
  localparam logic [2:0] CM_LOW  = 3'd1;
  localparam logic [2:0] CM_HALF = 3'd2;
  localparam logic [2:0] CM_FULL = 3'd3;
  localparam logic [2:0] CM_AUTO = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_OVERCURRENT = 3'd0;
  localparam logic [2:0] REG_DARK_LIMIT  = 3'd1;
  localparam logic [2:0] REG_MID_LIMIT   = 3'd2;
  localparam logic [2:0] REG_AUTO_LOW    = 3'd3;
  localparam logic [2:0] REG_AUTO_MID    = 3'd4;

  // Configuration reset values
  localparam logic [12:0] RST_OVERCURRENT = 13'd2500;
  localparam logic [11:0] RST_DARK_LIMIT  = 12'd100;
  localparam logic [11:0] RST_MID_LIMIT   = 12'd400;
  localparam logic [9:0]  RST_AUTO_LOW    = 10'd200;
  localparam logic [9:0]  RST_AUTO_MID    = 10'd500;

  // Fixed levels
  localparam logic [9:0] LEVEL_LOW     = 10'd250;
  localparam logic [9:0] LEVEL_HALF    = 10'd500;
  localparam logic [9:0] LEVEL_TWINKLE = 10'd350;

  // SOS pattern length
  localparam int         SOS_PERIOD = 10;
  localparam logic [3:0] SOS_LAST   = 4'(SOS_PERIOD - 1);

  // Power: (v * i + 5000) / 10000 as a multiply by ceil(2^39 / 10000), shift by 39.
  // Exact for every sum below 2^25.
  localparam logic [24:0] POWER_ROUND = 25'd5000;
  localparam logic [25:0] POWER_RECIP = 26'd54975582;
  localparam int          POWER_SHIFT = 39;

  typedef struct packed {
    logic [12:0] overcurrent_limit_ma;
    logic [11:0] dark_ambient_limit;
    logic [11:0] mid_ambient_limit;
    logic [9:0]  auto_low_level;
    logic [9:0]  auto_mid_level;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  warm_level;
    logic [9:0]  blue_level;
    logic [9:0]  green_level;
    logic [9:0]  red_level;
    logic [11:0] power_estimate;
    logic        lamp_on;
    logic [2:0]  white_mode_now;
    logic [2:0]  colour_mode_now;
    logic        rejected;
  } result_t;

  // Lit steps of the SOS pattern
  function automatic logic sos_lit(input logic [3:0] step);
    logic lit;
    unique case (step)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8: lit = 1'b1;
      default:                            lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rlmc_power_div.sv
// Rounded divide of the voltage-current product by 10000 through a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module rlmc_power_div (
  input  wire logic [24:0] product,
  output logic      [11:0] power
);
  import rlmc_pkg::*;

  logic [24:0] rounded;
  logic [50:0] scaled;

  // Sum stays below 2^25 for all 12 x 13 bit operands
  assign rounded = product + POWER_ROUND;
  assign scaled  = {26'd0, rounded} * {25'd0, POWER_RECIP};
  // Quotient never exceeds 3354, so it fits 12 bits without saturation
  assign power   = scaled[POWER_SHIFT +: 12];

endmodule

`default_nettype wire

FILE: rtl/rlmc_core.sv
// Mode state registers and next-state logic for one item.
`timescale 1ns / 1ps
`default_nettype none

module rlmc_core #(
  parameter int unsigned PWM_MAX = 1000
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [2:0]        opcode,
  input  wire logic [2:0]        mode_value,
  input  wire logic [1:0]        switch_kind,
  input  wire logic              system_active,
  input  wire logic [11:0]       ambient_level,
  input  wire logic [12:0]       drive_current_ma,
  input  wire logic [11:0]       power_q,
  input  wire rlmc_pkg::cfg_t    cfg,
  output rlmc_pkg::result_t      result
);
  import rlmc_pkg::*;

  localparam logic [9:0] PwmLevel = 10'(PWM_MAX);

  logic [2:0]  white_mode, white_mode_next;
  logic [2:0]  colour_mode, colour_mode_next;
  logic [3:0]  sos_step, sos_step_next;
  logic        twinkle_phase, twinkle_phase_next;
  logic [9:0]  warm, warm_next;
  logic [9:0]  blue, blue_next;
  logic [9:0]  green, green_next;
  logic [9:0]  red, red_next;
  logic [11:0] power, power_next;
  logic        lamp, lamp_next;
  logic        rejected;

  logic        do_set, do_shut;
  logic [9:0]  set_w, set_b, set_g, set_r;
  logic [9:0]  colour_lvl, auto_lvl;
  logic [9:0]  cl_w, cl_b, cl_g, cl_r;

  function automatic logic [9:0] clamp_lvl(input logic [9:0] v);
    return (v > PwmLevel) ? PwmLevel : v;
  endfunction

  always_comb begin
    unique case (colour_mode)
      CM_LOW:           colour_lvl = LEVEL_LOW;
      CM_HALF:          colour_lvl = LEVEL_HALF;
      CM_FULL, CM_AUTO: colour_lvl = PwmLevel;
      default:          colour_lvl = '0;
    endcase
  end

  always_comb begin
    priority if (ambient_level < cfg.dark_ambient_limit) begin
      auto_lvl = cfg.auto_low_level;
    end else if (ambient_level < cfg.mid_ambient_limit) begin
      auto_lvl = cfg.auto_mid_level;
    end else begin
      auto_lvl = PwmLevel;
    end
  end

  always_comb begin
    white_mode_next    = white_mode;
    colour_mode_next   = colour_mode;
    sos_step_next      = sos_step;
    twinkle_phase_next = twinkle_phase;
    rejected           = 1'b0;
    do_set             = 1'b0;
    do_shut            = 1'b0;
    set_w              = '0;
    set_b              = '0;
    set_g              = '0;
    set_r              = '0;

    unique case (opcode)
      OP_TICK: begin
        if (drive_current_ma > cfg.overcurrent_limit_ma || !system_active) begin
          white_mode_next  = WM_OFF;
          colour_mode_next = CM_OFF;
          do_shut          = 1'b1;
        end else begin
          unique case (white_mode)
            WM_LOW, WM_HALF, WM_FULL, WM_AUTO: begin
              do_set = 1'b1;
              unique case (white_mode)
                WM_LOW:  set_w = LEVEL_LOW;
                WM_HALF: set_w = LEVEL_HALF;
                WM_FULL: set_w = PwmLevel;
                default: set_w = auto_lvl;
              endcase
              set_b = colour_lvl;
              set_g = colour_lvl;
              set_r = colour_lvl;
            end
            WM_SOS: begin
              do_set        = 1'b1;
              sos_step_next = (sos_step >= SOS_LAST) ? 4'd0 : sos_step + 4'd1;
              if (sos_lit(sos_step_next)) begin
                set_w = PwmLevel;
                set_r = PwmLevel;
              end
            end
            WM_TWINKLE: begin
              do_set             = 1'b1;
              twinkle_phase_next = ~twinkle_phase;
              if (twinkle_phase_next) begin
                set_w = LEVEL_TWINKLE;
                set_b = colour_lvl;
                set_r = colour_lvl;
              end
            end
            default: do_shut = 1'b1;
          endcase
        end
      end
      OP_SET_WHITE: white_mode_next = mode_value;
      OP_SET_COLOUR: colour_mode_next = mode_value;
      OP_SWITCH: begin
        unique case (switch_kind)
          SW_ON: begin
            if (white_mode == WM_OFF) white_mode_next = WM_FULL;
            if (colour_mode == CM_OFF) colour_mode_next = CM_LOW;
          end
          SW_OFF: begin
            white_mode_next  = WM_OFF;
            colour_mode_next = CM_OFF;
            do_shut          = 1'b1;
          end
          SW_TOGGLE: begin
            if (white_mode == WM_OFF && colour_mode == CM_OFF) begin
              white_mode_next  = WM_FULL;
              colour_mode_next = CM_LOW;
            end else begin
              white_mode_next  = WM_OFF;
              colour_mode_next = CM_OFF;
              do_shut          = 1'b1;
            end
          end
          default: rejected = 1'b1;
        endcase
      end
      OP_CYCLE: white_mode_next = (white_mode < WM_TWINKLE) ? white_mode + 3'd1 : WM_OFF;
      default: ;
    endcase
  end

  assign cl_w = clamp_lvl(set_w);
  assign cl_b = clamp_lvl(set_b);
  assign cl_g = clamp_lvl(set_g);
  assign cl_r = clamp_lvl(set_r);

  always_comb begin
    warm_next  = warm;
    blue_next  = blue;
    green_next = green;
    red_next   = red;
    power_next = power;
    lamp_next  = lamp;
    priority if (do_shut) begin
      warm_next  = '0;
      blue_next  = '0;
      green_next = '0;
      red_next   = '0;
      power_next = '0;
      lamp_next  = 1'b0;
    end else if (do_set) begin
      warm_next  = cl_w;
      blue_next  = cl_b;
      green_next = cl_g;
      red_next   = cl_r;
      power_next = power_q;
      lamp_next  = |{cl_w, cl_b, cl_g, cl_r};
    end else if (opcode == OP_SET_WHITE && mode_value == WM_OFF && colour_mode == CM_OFF) begin
      // White off with colour off drops the lamp flag but leaves the levels
      lamp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      white_mode    <= WM_OFF;
      colour_mode   <= CM_OFF;
      sos_step      <= '0;
      twinkle_phase <= 1'b0;
      warm          <= '0;
      blue          <= '0;
      green         <= '0;
      red           <= '0;
      power         <= '0;
      lamp          <= 1'b0;
    end else if (advance) begin
      white_mode    <= white_mode_next;
      colour_mode   <= colour_mode_next;
      sos_step      <= sos_step_next;
      twinkle_phase <= twinkle_phase_next;
      warm          <= warm_next;
      blue          <= blue_next;
      green         <= green_next;
      red           <= red_next;
      power         <= power_next;
      lamp          <= lamp_next;
    end
  end

  always_comb begin
    result.warm_level      = warm_next;
    result.blue_level      = blue_next;
    result.green_level     = green_next;
    result.red_level       = red_next;
    result.power_estimate  = power_next;
    result.lamp_on         = lamp_next;
    result.white_mode_now  = white_mode_next;
    result.colour_mode_now = colour_mode_next;
    result.rejected        = rejected;
  end

`ifndef ASSERT_OFF
  a_lamp_needs_level: assert property (@(posedge clk) disable iff (rst)
    lamp |-> (warm != '0 || blue != '0 || green != '0 || red != '0))
    else $error("lamp flag set with all levels zero");

  a_levels_clamped: assert property (@(posedge clk) disable iff (rst)
    (warm <= PwmLevel) && (blue <= PwmLevel) && (green <= PwmLevel) && (red <= PwmLevel))
    else $error("channel level above maximum");

  a_sos_in_range: assert property (@(posedge clk) disable iff (rst)
    sos_step <= SOS_LAST)
    else $error("sos step out of range");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(white_mode) && $stable(colour_mode) && $stable(lamp))
    else $error("mode state changed without an item");
`endif

endmodule

`default_nettype wire

FILE: rtl/rgbw_light_mode_controller.sv
// Top level of the RGBW light mode controller: config registers, item and result stages.
`timescale 1ns / 1ps
`default_nettype none

// Item-driven controller for four light channels (warm, blue, green, red).
// Each accepted item yields exactly one result item, in order. An item is
// captured in an input register (the supply voltage times drive current
// product is formed on the way in), then the mode logic and the power divide
// run combinationally into the result register. One item is accepted every
// cycle as long as the result side keeps taking items, and the input stage
// keeps accepting while a finished result waits, until both stages are full.
// Configuration writes take effect at the clock edge of the write; write
// them only while the block is idle. Levels are clamped to PWM_MAX;
// power_estimate is (voltage * current_mA + 5000) / 10000 on a level update
// and zero on shutdown.
module rgbw_light_mode_controller #(
  parameter int unsigned PWM_MAX = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [2:0]  mode_value,
  input  wire logic [1:0]  switch_kind,
  input  wire logic        system_active,
  input  wire logic [11:0] ambient_level,
  input  wire logic [12:0] drive_current_ma,
  input  wire logic [11:0] supply_voltage,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       warm_level,
  output logic [9:0]       blue_level,
  output logic [9:0]       green_level,
  output logic [9:0]       red_level,
  output logic [11:0]      power_estimate,
  output logic             lamp_on,
  output logic [2:0]       white_mode_now,
  output logic [2:0]       colour_mode_now,
  output logic             rejected,
  // configuration write port
  input  wire logic        cfg_write_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import rlmc_pkg::*;

  cfg_t        cfg;

  // input stage
  logic        s1_valid;
  logic [2:0]  s1_opcode;
  logic [2:0]  s1_mode_value;
  logic [1:0]  s1_switch_kind;
  logic        s1_system_active;
  logic [11:0] s1_ambient_level;
  logic [12:0] s1_drive_current_ma;
  logic [24:0] s1_product;

  logic        advance;
  logic [11:0] power_q;
  result_t     core_result;
  result_t     out_result;

  // Move the staged item into the result register when that register is free
  // or being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overcurrent_limit_ma <= RST_OVERCURRENT;
      cfg.dark_ambient_limit   <= RST_DARK_LIMIT;
      cfg.mid_ambient_limit    <= RST_MID_LIMIT;
      cfg.auto_low_level       <= RST_AUTO_LOW;
      cfg.auto_mid_level       <= RST_AUTO_MID;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_OVERCURRENT: cfg.overcurrent_limit_ma <= cfg_data;
        REG_DARK_LIMIT:  cfg.dark_ambient_limit   <= cfg_data[11:0];
        REG_MID_LIMIT:   cfg.mid_ambient_limit    <= cfg_data[11:0];
        REG_AUTO_LOW:    cfg.auto_low_level       <= cfg_data[9:0];
        REG_AUTO_MID:    cfg.auto_mid_level       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the item until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode           <= opcode;
      s1_mode_value       <= mode_value;
      s1_switch_kind      <= switch_kind;
      s1_system_active    <= system_active;
      s1_ambient_level    <= ambient_level;
      s1_drive_current_ma <= drive_current_ma;
      s1_product          <= {13'd0, supply_voltage} * {12'd0, drive_current_ma};
    end
  end

  rlmc_power_div u_power_div (
    .product (s1_product),
    .power   (power_q)
  );

  rlmc_core #(
    .PWM_MAX (PWM_MAX)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .opcode           (s1_opcode),
    .mode_value       (s1_mode_value),
    .switch_kind      (s1_switch_kind),
    .system_active    (s1_system_active),
    .ambient_level    (s1_ambient_level),
    .drive_current_ma (s1_drive_current_ma),
    .power_q          (power_q),
    .cfg              (cfg),
    .result           (core_result)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign warm_level      = out_result.warm_level;
  assign blue_level      = out_result.blue_level;
  assign green_level     = out_result.green_level;
  assign red_level       = out_result.red_level;
  assign power_estimate  = out_result.power_estimate;
  assign lamp_on         = out_result.lamp_on;
  assign white_mode_now  = out_result.white_mode_now;
  assign colour_mode_now = out_result.colour_mode_now;
  assign rejected        = out_result.rejected;

`ifndef ASSERT_OFF
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted item not staged");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item missing at output");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_opcode) && $stable(s1_product))
    else $error("staged item lost while stalled");

  a_result_only_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a staged item");
`endif

endmodule

`default_nettype wire
